// ----- design/three_button_press_classifier_top_assert.svh -----
// Assertion helpers for the press classifier; all checks run on i_clk and are
// disabled while i_rst_n is low.
`ifndef THREE_BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`define THREE_BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TBPC_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TBPC_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tbpc_pkg.sv -----
package tbpc_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int NUM_BTN   = 3;
    localparam int EV_W      = 4;

    // Lane order is also the event priority order
    localparam int BTN_PREV = 0;
    localparam int BTN_SEL  = 1;
    localparam int BTN_NEXT = 2;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd800;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS = 8'd0,
        CFG_DEBOUNCE   = 8'd1
    } t_cfg_idx;

    typedef enum logic [EV_W-1:0] {
        EV_NONE       = 4'd0,
        EV_PREV_SHORT = 4'd1,
        EV_SEL_SHORT  = 4'd2,
        EV_NEXT_SHORT = 4'd3,
        EV_SEL_LONG   = 4'd4,
        EV_NEXT_LONG  = 4'd5,
        EV_PTT_DOWN   = 4'd6,
        EV_PTT_UP     = 4'd7,
        EV_MENU       = 4'd8
    } t_event;

    // What one button lane found for the current item
    typedef struct packed {
        logic lead;       // leading edge this item
        logic long_hit;   // long threshold reached
        logic rel_ok;     // release after a press past debounce
        logic long_done;  // long flag as seen by this item
        logic down_cur;   // stored down flag
        logic down_nxt;   // down flag if the lane is updated
    } t_lane_res;

endpackage

// ----- design/tbpc_lane.sv -----
module tbpc_lane
    import tbpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pressed,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic [CFG_W-1:0] i_long_ms,
    input  logic [CFG_W-1:0] i_deb_ms,
    input  logic             i_apply,
    input  logic             i_mark_long,
    output t_lane_res        o_res
);

    logic              r_down;
    logic              r_long_done;
    logic [TIME_W-1:0] r_start;

    logic              w_lead;
    logic              w_release;
    logic [TIME_W-1:0] w_start;
    logic              w_ld;
    logic [TIME_W-1:0] w_held;
    logic              w_long_hit;
    logic              w_rel_ok;
    logic              n_long_done;

    // Press timing, with a leading edge taken into account first
    always_comb begin
        w_lead      = i_pressed & ~r_down;
        w_release   = ~i_pressed & r_down;
        w_start     = w_lead ? i_now_ms : r_start;
        w_ld        = w_lead ? 1'b0 : r_long_done;
        w_held      = i_now_ms - w_start;
        w_long_hit  = i_pressed & ~w_ld & (w_held >= {{(TIME_W-CFG_W){1'b0}}, i_long_ms});
        w_rel_ok    = w_release & (w_held >= {{(TIME_W-CFG_W){1'b0}}, i_deb_ms});
        n_long_done = w_ld | w_long_hit;
    end

    always_comb begin
        o_res.lead      = w_lead;
        o_res.long_hit  = w_long_hit;
        o_res.rel_ok    = w_rel_ok;
        o_res.long_done = w_ld;
        o_res.down_cur  = r_down;
        o_res.down_nxt  = i_pressed;
    end

    // Lane state: updated when the merge lets this lane run, or marked by a chord
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down      <= 1'b0;
            r_long_done <= 1'b0;
            r_start     <= '0;
        end else if (i_apply) begin
            r_down      <= i_pressed;
            r_long_done <= n_long_done;
            r_start     <= w_start;
        end else if (i_mark_long) begin
            r_long_done <= 1'b1;
        end
    end

endmodule

// ----- design/tbpc_merge.sv -----
`include "three_button_press_classifier_top_assert.svh"

module tbpc_merge
    import tbpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_prev_pressed,
    input  logic               i_next_pressed,
    input  t_lane_res          i_lane [NUM_BTN],
    output logic [NUM_BTN-1:0] o_apply,
    output logic               o_mark_long,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [EV_W-1:0]    o_event_code,
    output logic               o_prev_held,
    output logic               o_select_held,
    output logic               o_next_held
);

    typedef struct packed {
        logic [EV_W-1:0]    ev;
        logic [NUM_BTN-1:0] held;
    } t_out;

    logic r_talk;
    logic r_chord_done;
    logic n_talk;
    logic n_chord_done;

    logic r_out_valid;
    logic r_skid_valid;
    t_out r_out;
    t_out r_skid;
    t_out w_new;

    logic               w_in_fire;
    logic               w_out_fire;
    logic               w_chord;
    t_event             w_ev0;
    t_event             w_ev1;
    t_event             w_ev2;
    t_event             w_event;
    logic               w_talk_lane;
    logic [NUM_BTN-1:0] w_run;

    assign o_in_ready = ~r_skid_valid;
    assign w_in_fire  = i_in_valid & o_in_ready;
    assign w_out_fire = r_out_valid & i_out_ready;

    // Chord detection and rearm
    always_comb begin
        w_chord = i_prev_pressed & i_next_pressed & ~r_chord_done;
        if (w_chord) begin
            n_chord_done = 1'b1;
        end else if (~i_prev_pressed & ~i_next_pressed) begin
            n_chord_done = 1'b0;
        end else begin
            n_chord_done = r_chord_done;
        end
    end

    // Prev lane events and push-to-talk tracking
    always_comb begin
        priority if (i_lane[BTN_PREV].long_hit) begin
            w_ev0 = EV_PTT_DOWN;
        end else if (i_lane[BTN_PREV].rel_ok && r_talk) begin
            w_ev0 = EV_PTT_UP;
        end else if (i_lane[BTN_PREV].rel_ok && !i_lane[BTN_PREV].long_done) begin
            w_ev0 = EV_PREV_SHORT;
        end else begin
            w_ev0 = EV_NONE;
        end

        priority if (i_lane[BTN_PREV].long_hit) begin
            w_talk_lane = 1'b1;
        end else if (i_lane[BTN_PREV].lead || (i_lane[BTN_PREV].rel_ok && r_talk)) begin
            w_talk_lane = 1'b0;
        end else begin
            w_talk_lane = r_talk;
        end
    end

    // Select and next lane events
    always_comb begin
        priority if (i_lane[BTN_SEL].long_hit) begin
            w_ev1 = EV_SEL_LONG;
        end else if (i_lane[BTN_SEL].rel_ok && !i_lane[BTN_SEL].long_done) begin
            w_ev1 = EV_SEL_SHORT;
        end else begin
            w_ev1 = EV_NONE;
        end

        priority if (i_lane[BTN_NEXT].long_hit) begin
            w_ev2 = EV_NEXT_LONG;
        end else if (i_lane[BTN_NEXT].rel_ok && !i_lane[BTN_NEXT].long_done) begin
            w_ev2 = EV_NEXT_SHORT;
        end else begin
            w_ev2 = EV_NONE;
        end
    end

    // Priority pick: chord first, then the first lane with an event
    always_comb begin
        if (w_chord) begin
            w_run   = '0;
            w_event = r_talk ? EV_PTT_UP : EV_MENU;
            n_talk  = 1'b0;
        end else begin
            w_run[BTN_PREV] = 1'b1;
            w_run[BTN_SEL]  = (w_ev0 == EV_NONE);
            w_run[BTN_NEXT] = (w_ev0 == EV_NONE) && (w_ev1 == EV_NONE);
            n_talk          = w_talk_lane;
            if (w_ev0 != EV_NONE) begin
                w_event = w_ev0;
            end else if (w_ev1 != EV_NONE) begin
                w_event = w_ev1;
            end else begin
                w_event = w_ev2;
            end
        end
    end

    always_comb begin
        w_new.ev = w_event;
        for (int k = 0; k < NUM_BTN; k++) begin
            w_new.held[k] = w_run[k] ? i_lane[k].down_nxt : i_lane[k].down_cur;
        end
    end

    assign o_apply     = w_in_fire ? w_run : '0;
    assign o_mark_long = w_in_fire & w_chord;

    // Shared state of the classifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_talk       <= 1'b0;
            r_chord_done <= 1'b0;
        end else if (w_in_fire) begin
            r_talk       <= n_talk;
            r_chord_done <= n_chord_done;
        end
    end

    // Output register with a skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_fire) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_fire;
            end
        end else if (w_in_fire) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_fire) begin
                r_out <= w_new;
            end
        end else if (w_in_fire) begin
            if (r_out_valid) begin
                r_skid <= w_new;
            end else begin
                r_out <= w_new;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_code  = r_out.ev;
    assign o_prev_held   = r_out.held[BTN_PREV];
    assign o_select_held = r_out.held[BTN_SEL];
    assign o_next_held   = r_out.held[BTN_NEXT];

    `TBPC_AST_IMP(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with output empty")
    `TBPC_AST_NXT(a_chord_latched, w_in_fire && w_chord, r_chord_done, "chord not latched")
    `TBPC_AST_IMP(a_talk_from_ptt_down, $rose(r_talk),
        $past(w_in_fire) && ($past(w_event) == EV_PTT_DOWN), "talk armed without ptt down")

endmodule

// ----- design/three_button_press_classifier_top.sv -----
// Three-button press classifier (prev, select, next). Each input item is one
// poll: a millisecond timestamp and the three pressed levels; each item gives
// exactly one result item with an event code and the held flags after the poll.
// One item is taken every cycle while the skid stage is empty; the three button
// lanes and the chord/priority merge are combinational, and the result sits in
// an output register backed by a one-entry skid stage, so input is refused only
// when both are full. Register 0 sets the long-press threshold (reset 800 ms),
// register 1 the debounce time (reset 30 ms); the configuration port is always
// ready and other indexes are ignored.
module three_button_press_classifier_top
    import tbpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [TIME_W-1:0]    i_now_ms,
    input  logic                 i_prev_pressed,
    input  logic                 i_select_pressed,
    input  logic                 i_next_pressed,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [EV_W-1:0]      o_event_code,
    output logic                 o_prev_held,
    output logic                 o_select_held,
    output logic                 o_next_held
);

    logic [CFG_W-1:0]   r_long_ms;
    logic [CFG_W-1:0]   r_deb_ms;
    logic [NUM_BTN-1:0] w_level;
    logic [NUM_BTN-1:0] w_apply;
    logic               w_mark_long;
    t_lane_res          w_lane [NUM_BTN];

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ms <= LONG_PRESS_RST;
            r_deb_ms  <= DEBOUNCE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LONG_PRESS: r_long_ms <= i_cfg_data;
                CFG_DEBOUNCE:   r_deb_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_level[BTN_PREV] = i_prev_pressed;
    assign w_level[BTN_SEL]  = i_select_pressed;
    assign w_level[BTN_NEXT] = i_next_pressed;

    // One lane per button; the chord marks only prev and next
    for (genvar k = 0; k < NUM_BTN; k++) begin : g_lane
        tbpc_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_pressed   (w_level[k]),
            .i_now_ms    (i_now_ms),
            .i_long_ms   (r_long_ms),
            .i_deb_ms    (r_deb_ms),
            .i_apply     (w_apply[k]),
            .i_mark_long (w_mark_long && (k != BTN_SEL)),
            .o_res       (w_lane[k])
        );
    end

    tbpc_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_prev_pressed (i_prev_pressed),
        .i_next_pressed (i_next_pressed),
        .i_lane         (w_lane),
        .o_apply        (w_apply),
        .o_mark_long    (w_mark_long),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_code   (o_event_code),
        .o_prev_held    (o_prev_held),
        .o_select_held  (o_select_held),
        .o_next_held    (o_next_held)
    );

endmodule
